@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define RSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define RSS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rss_pkg.sv @@
// Package: signature tables, verdict codes and shared types of the scanner.
`timescale 1ns / 1ps
package rss_pkg;

  localparam int WORD_MAX   = 11;
  localparam int SQL_WORDS  = 11;
  localparam int XSS_WORDS  = 9;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register indexes (paddr[2] selects the register)
  localparam logic REG_RATE_THRESHOLD = 1'b0;
  localparam logic [15:0] RATE_THRESHOLD_RESET = 16'd50;

  // verdict codes
  localparam logic [1:0] VERDICT_CLEAN = 2'd0;
  localparam logic [1:0] VERDICT_SQL   = 2'd1;
  localparam logic [1:0] VERDICT_XSS   = 2'd2;
  localparam logic [1:0] VERDICT_RATE  = 2'd3;

  // SQL word indexes
  localparam int W_UNION  = 0;
  localparam int W_SELECT = 1;
  localparam int W_DROP   = 2;
  localparam int W_TABLE  = 3;
  localparam int W_INSERT = 4;
  localparam int W_INTO   = 5;
  localparam int W_VALUES = 6;
  localparam int W_DELETE = 7;
  localparam int W_FROM   = 8;
  localparam int W_UPDATE = 9;
  localparam int W_SET    = 10;

  // words are right-justified: the last character sits in the low byte
  localparam logic [8*WORD_MAX-1:0] SQL_TEXT [SQL_WORDS] = '{
    "union", "select", "drop", "table", "insert", "into",
    "values", "delete", "from", "update", "set"
  };
  localparam int SQL_LEN [SQL_WORDS] = '{5, 6, 4, 5, 6, 4, 6, 6, 4, 6, 3};

  localparam logic [8*WORD_MAX-1:0] XSS_TEXT [XSS_WORDS] = '{
    "<script", "onload=", "onerror=", "<img", "<iframe",
    "javascript:", "eval(", "expression(", "vbscript:"
  };
  localparam int XSS_LEN [XSS_WORDS] = '{7, 7, 8, 4, 7, 11, 5, 11, 9};

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] request_count;
  } rss_item_t;

  // Per-position compare of one byte against a literal; bit k is character k.
  function automatic logic [WORD_MAX-1:0] lit_eq(input logic [8*WORD_MAX-1:0] text,
                                                 input int len, input logic [7:0] c);
    logic [WORD_MAX-1:0] eq;
    eq = '0;
    for (int k = 0; k < WORD_MAX; k++) begin
      if (k < len) begin
        eq[k] = (text[8*(len-1-k) +: 8] == c);
      end
    end
    return eq;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= "A" && c <= "Z") begin
      f = c + 8'h20;
    end
    return f;
  endfunction

endpackage

@@ design/rss_ifs.sv @@
// Channel interfaces: request bytes in, verdicts out.
`timescale 1ns / 1ps
interface rss_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] request_count;

  modport source (output valid, data_byte, last_byte, request_count, input ready);
  modport sink (input valid, data_byte, last_byte, request_count, output ready);
endinterface

interface rss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

@@ design/rss_cfg.sv @@
// APB register block holding the rate threshold.
`timescale 1ns / 1ps
module rss_cfg import rss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [15:0]           rate_threshold
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_threshold <= RATE_THRESHOLD_RESET;
    end else if (wr_en && paddr[2] == REG_RATE_THRESHOLD) begin
      rate_threshold <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RATE_THRESHOLD) begin
      prdata = {{(APB_DATA_W-16){1'b0}}, rate_threshold};
    end
  end

endmodule

@@ design/rss_scan.sv @@
// Shift-and matchers for all signatures, sticky flags and verdict logic.
`timescale 1ns / 1ps
module rss_scan import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  rss_item_t   item,
  input  logic [15:0] rate_threshold,
  output logic [1:0]  verdict
);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR  = "*";

  logic [WORD_MAX-1:0] sql_prog [SQL_WORDS];
  logic [WORD_MAX-1:0] sql_step [SQL_WORDS];
  logic [SQL_WORDS-1:0] sql_done;
  logic [WORD_MAX-1:0] xss_prog [XSS_WORDS];
  logic [WORD_MAX-1:0] xss_step [XSS_WORDS];
  logic [XSS_WORDS-1:0] xss_done;
  logic [3:0] gap_armed;
  logic [3:0] gap_armed_next;
  logic [1:0] ws_run;
  logic [1:0] ws_run_next;
  logic [7:0] prev_byte;
  logic       sql_found;
  logic       xss_found;
  logic       sql_found_next;
  logic       xss_found_next;
  logic [7:0] c;
  logic [7:0] fc;
  logic       is_ws;
  logic       is_eol;
  logic       exact_hit;
  logic       gap_hit;

  assign c  = item.data_byte;
  assign fc = fold_case(c);

  for (genvar gi = 0; gi < SQL_WORDS; gi++) begin : g_sql
    localparam int LEN = SQL_LEN[gi];
    logic eq_first;
    logic [WORD_MAX-1:0] eq;
    assign eq = lit_eq(SQL_TEXT[gi], LEN, fc);
    // "into" and "from" may only start inside the whitespace run after their head
    if (gi == W_INTO) begin : g_into
      assign eq_first = ws_run[0];
    end else if (gi == W_FROM) begin : g_from
      assign eq_first = ws_run[1];
    end else begin : g_any
      assign eq_first = 1'b1;
    end
    assign sql_step[gi] = {sql_prog[gi][WORD_MAX-2:0], eq_first} & eq;
    assign sql_done[gi] = sql_step[gi][LEN-1];
  end

  for (genvar gi = 0; gi < XSS_WORDS; gi++) begin : g_xss
    localparam int LEN = XSS_LEN[gi];
    logic [WORD_MAX-1:0] eq;
    assign eq = lit_eq(XSS_TEXT[gi], LEN, fc);
    assign xss_step[gi] = {xss_prog[gi][WORD_MAX-2:0], 1'b1} & eq;
    assign xss_done[gi] = xss_step[gi][LEN-1];
  end

  always_comb begin
    is_ws  = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    is_eol = (c == CH_CR) || (c == CH_LF);

    ws_run_next[0] = is_ws && (sql_prog[W_INSERT][SQL_LEN[W_INSERT]-1] || ws_run[0]);
    ws_run_next[1] = is_ws && (sql_prog[W_DELETE][SQL_LEN[W_DELETE]-1] || ws_run[1]);

    gap_hit = (sql_done[W_SELECT] && gap_armed[0]) ||
              (sql_done[W_TABLE]  && gap_armed[1]) ||
              (sql_done[W_SET]    && gap_armed[2]) ||
              (sql_done[W_VALUES] && gap_armed[3]) ||
              sql_done[W_FROM];
    exact_hit = (c == CH_SEMI) || (c == CH_EQ) ||
                (prev_byte == CH_DASH  && c == CH_DASH) ||
                (prev_byte == CH_SLASH && c == CH_STAR) ||
                (prev_byte == CH_STAR  && c == CH_SLASH);

    // a line break disarms all pending gaps; new heads arm after that
    gap_armed_next = (is_eol ? 4'b0000 : gap_armed) |
                     {sql_done[W_INTO], sql_done[W_UPDATE], sql_done[W_DROP], sql_done[W_UNION]};

    sql_found_next = sql_found || gap_hit || exact_hit;
    xss_found_next = xss_found || (|xss_done);

    if (sql_found_next) begin
      verdict = VERDICT_SQL;
    end else if (xss_found_next) begin
      verdict = VERDICT_XSS;
    end else if (item.request_count > rate_threshold) begin
      verdict = VERDICT_RATE;
    end else begin
      verdict = VERDICT_CLEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      for (int i = 0; i < SQL_WORDS; i++) begin
        sql_prog[i] <= '0;
      end
      for (int i = 0; i < XSS_WORDS; i++) begin
        xss_prog[i] <= '0;
      end
      gap_armed <= '0;
      ws_run    <= '0;
      prev_byte <= '0;
      sql_found <= 1'b0;
      xss_found <= 1'b0;
    end else if (step) begin
      for (int i = 0; i < SQL_WORDS; i++) begin
        sql_prog[i] <= sql_step[i];
      end
      for (int i = 0; i < XSS_WORDS; i++) begin
        xss_prog[i] <= xss_step[i];
      end
      gap_armed <= gap_armed_next;
      ws_run    <= ws_run_next;
      prev_byte <= c;
      sql_found <= sql_found_next;
      xss_found <= xss_found_next;
    end
  end

endmodule

@@ design/request_signature_scanner_core.sv @@
// Top level of the request signature scanner.
`timescale 1ns / 1ps
// Request signature scanner.
// in_ch carries the request text one byte per transaction: the query, one
// space, then the post data, with last_byte set on the final byte and
// request_count sampled on that byte. out_ch carries one verdict transaction
// per request: 1 SQL signature, else 2 script signature, else 3 when
// request_count exceeds rate_threshold, else 0. Bytes without last_byte give
// no output transaction.
// rate_threshold sits at APB byte address 0; write it only while idle.
// Throughput: one byte per cycle, save for the last-byte stall below. Every
// byte passes the input register, then all shift-and matchers update in
// parallel in combinational logic, and the verdict is loaded into the output
// register when its last byte leaves the input register.
// Reset: rate_threshold returns to 50, all matcher state and flags clear, both
// channels are empty. Stalls: while a verdict waits in the output register,
// ordinary bytes keep flowing; only a last byte waits in the input register,
// and in_ch.ready drops until the waiting verdict is taken.
module request_signature_scanner_core import rss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rss_in_if.sink                in_ch,
  rss_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0] rate_threshold;
  rss_item_t   s1_item;
  logic        s1_valid;
  logic        slot_free;
  logic        advance;
  logic [1:0]  verdict_next;
  logic        in_take;
  logic        out_valid;
  logic [1:0]  out_verdict;

  rss_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .rate_threshold (rate_threshold)
  );

  // Output slot frees up when empty or being taken this cycle.
  assign slot_free = !out_valid || out_ch.ready;
  // Advance the held byte; a last byte also needs the output slot.
  assign advance   = s1_valid && (!s1_item.last_byte || slot_free);
  assign in_ch.ready = !s1_valid || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  rss_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (s1_item),
    .rate_threshold (rate_threshold),
    .verdict        (verdict_next)
  );

  // Input register: control with reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.data_byte     <= in_ch.data_byte;
      s1_item.last_byte     <= in_ch.last_byte;
      s1_item.request_count <= in_ch.request_count;
    end
  end

  // Result register: load the verdict on a last byte, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.last_byte) begin
      out_verdict <= verdict_next;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.verdict = out_verdict;

endmodule

@@ design/rss_checker.sv @@
// Port-level checker for the scanner and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] verdict
);

  `RSS_ASSERT(a_out_valid_hold, out_valid && !out_ready |=> out_valid, "verdict dropped while stalled")
  `RSS_ASSERT(a_out_data_hold, out_valid && !out_ready |=> $stable(verdict), "verdict changed while stalled")
  `RSS_ASSERT(a_ready_when_slot_free, !out_valid |-> in_ready, "input stalled with empty output slot")
  `RSS_ASSERT_RST(a_reset_empty_out, rst |=> !out_valid, "output valid right after reset")
  `RSS_ASSERT_RST(a_reset_ready_in, rst |=> in_ready, "input not ready right after reset")

endmodule

bind request_signature_scanner_core rss_checker u_rss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .verdict   (out_ch.verdict)
);

@@ verif/request_signature_scanner_core_test.sv @@
// Testbench for the request signature scanner: directed and random requests checked per verdict.
`timescale 1ns / 1ps
module request_signature_scanner_core_test;
  import rss_pkg::*;

  typedef logic [7:0] text_q_t [$];

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 7;
  // Drain wait after the last verdict, so trailing ordinary bytes are through
  // the matchers before a register write.
  localparam int PIPE_DRAIN = 6;
  localparam int LONG_HOLD = 200;
  localparam int RANDOM_PHASE_BYTES = 115;
  localparam int RANDOM_PHASE_MIN_VERDICTS = 12;
  localparam longint TIMEOUT_NS = 2_000_000;

  localparam logic [APB_ADDR_W-1:0] RATE_THRESHOLD_ADDR = {REG_RATE_THRESHOLD, 2'b00};
  // next slot past the register list; writes there must be ignored
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'b100;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rss_in_if in_ch ();
  rss_out_if out_ch ();

  request_signature_scanner_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Signature tables of the predictor, lower case; letters are folded before
  // comparison, every other byte is compared as is.
  string sql_keyword [SQL_WORDS] = '{
    "union", "select", "drop", "table", "insert", "into",
    "values", "delete", "from", "update", "set"
  };
  string script_keyword [XSS_WORDS] = '{
    "<script", "onload=", "onerror=", "<img", "<iframe",
    "javascript:", "eval(", "expression(", "vbscript:"
  };
  string filler_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 &?.%_+";

  // Predictor state: one shift-and progress vector per literal, plus the
  // gap, whitespace-run and two-byte trackers and the sticky hit flags.
  logic [15:0] sql_prog [SQL_WORDS];
  logic [15:0] script_prog [XSS_WORDS];
  logic [3:0] gap_open;
  logic [1:0] ws_run;
  logic [7:0] prev_char;
  bit sql_hit;
  bit script_hit;
  logic [15:0] rate_limit;

  logic [1:0] verdicts_due [$];
  int mismatches = 0;

  // Stall knobs shared by the test tasks and the verdict sink.
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;
  int sink_hold_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 9);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
           c == CHAR_FF || c == CHAR_CR;
  endfunction

  // One shift-and step: bit k set means the first k+1 characters just matched.
  function automatic logic [15:0] shift_and(input logic [15:0] prog, input string word,
                                            input logic [7:0] c);
    logic [15:0] eq;
    eq = '0;
    for (int k = 0; k < word.len(); k++) begin
      if (8'(word[k]) == c) begin
        eq[k] = 1'b1;
      end
    end
    return ((prog << 1) | 16'd1) & eq;
  endfunction

  task automatic clear_scan_state();
    foreach (sql_prog[i]) sql_prog[i] = '0;
    foreach (script_prog[i]) script_prog[i] = '0;
    gap_open = '0;
    ws_run = '0;
    prev_char = '0;
    sql_hit = 1'b0;
    script_hit = 1'b0;
  endtask

  // Advance the predictor by one accepted byte; on the last byte of a request
  // queue the verdict it must produce and start the next request clean.
  task automatic scan_request_byte(input logic [7:0] c, input logic is_last,
                                   input logic [15:0] count);
    logic [7:0] f;
    logic [15:0] m;
    bit done [SQL_WORDS];
    bit insert_head;
    bit delete_head;
    bit ws;
    logic [1:0] ws_old;
    logic [1:0] verdict;
    f = lower_ascii(c);
    insert_head = sql_prog[W_INSERT][5];
    delete_head = sql_prog[W_DELETE][5];
    ws_old = ws_run;
    for (int i = 0; i < SQL_WORDS; i++) begin
      m = shift_and(sql_prog[i], sql_keyword[i], f);
      // "into" and "from" may only start inside the whitespace run after their head
      if ((i == W_INTO && !ws_old[0]) || (i == W_FROM && !ws_old[1])) begin
        m[0] = 1'b0;
      end
      sql_prog[i] = m;
      done[i] = m[sql_keyword[i].len() - 1];
    end
    ws = is_space(c);
    ws_run = {ws && (delete_head || ws_old[1]), ws && (insert_head || ws_old[0])};
    if ((done[W_SELECT] && gap_open[0]) || (done[W_TABLE] && gap_open[1]) ||
        (done[W_SET] && gap_open[2]) || (done[W_VALUES] && gap_open[3]) ||
        done[W_FROM]) begin
      sql_hit = 1'b1;
    end
    if (c == ";" || c == "=" || (prev_char == "-" && c == "-") ||
        (prev_char == "/" && c == "*") || (prev_char == "*" && c == "/")) begin
      sql_hit = 1'b1;
    end
    // a line break closes every open gap; completed heads open theirs
    if (c == CHAR_CR || c == CHAR_LF) begin
      gap_open = '0;
    end
    if (done[W_UNION]) gap_open[0] = 1'b1;
    if (done[W_DROP]) gap_open[1] = 1'b1;
    if (done[W_UPDATE]) gap_open[2] = 1'b1;
    if (done[W_INTO]) gap_open[3] = 1'b1;
    for (int i = 0; i < XSS_WORDS; i++) begin
      m = shift_and(script_prog[i], script_keyword[i], f);
      script_prog[i] = m;
      if (m[script_keyword[i].len() - 1]) begin
        script_hit = 1'b1;
      end
    end
    prev_char = c;
    if (is_last) begin
      if (sql_hit) begin
        verdict = VERDICT_SQL;
      end else if (script_hit) begin
        verdict = VERDICT_XSS;
      end else if (count > rate_limit) begin
        verdict = VERDICT_RATE;
      end else begin
        verdict = VERDICT_CLEAN;
      end
      verdicts_due.push_back(verdict);
      clear_scan_state();
    end
  endtask

  // Offer one byte, hold it until the transaction completes, then maybe idle.
  // valid stays high across back-to-back bytes.
  task automatic send_byte(input logic [7:0] c, input logic is_last, input logic [15:0] count);
    int gap;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= c;
    in_ch.last_byte <= is_last;
    in_ch.request_count <= count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_request_byte(c, is_last, count);
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Send a whole request text; the count only matters on the last byte, so the
  // others carry random counts.
  task automatic send_request(input text_q_t text, input logic [15:0] count);
    for (int i = 0; i < text.size(); i++) begin
      if (i == text.size() - 1) begin
        send_byte(text[i], 1'b1, count);
      end else begin
        send_byte(text[i], 1'b0, 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic send_string(input string s, input logic [15:0] count);
    text_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_request(text, count);
  endtask

  // Drop valid and wait until every verdict is in and the matchers are quiet.
  task automatic wait_for_verdicts();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == RATE_THRESHOLD_ADDR) begin
      rate_limit = data[15:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_threshold_readback();
    logic [APB_DATA_W-1:0] got;
    apb_read(RATE_THRESHOLD_ADDR, got);
    if (got[15:0] !== rate_limit) begin
      report_mismatch($sformatf("rate_threshold reads %0d, want %0d", got[15:0], rate_limit));
    end
  endtask

  // --- random request text -------------------------------------------------

  task automatic add_filler(ref text_q_t text, input int n);
    repeat (n) text.push_back(filler_chars[$urandom_range(0, filler_chars.len() - 1)]);
  endtask

  // Append a literal with the case of each letter chosen at random.
  task automatic add_word(ref text_q_t text, input string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
        c = c ^ 8'h20;
      end
      text.push_back(c);
    end
  endtask

  task automatic add_space_run(ref text_q_t text, input int n);
    logic [7:0] spaces [6] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
    repeat (n) text.push_back(spaces[$urandom_range(0, 5)]);
  endtask

  // Filler between a head and its tail; now and then a line break closes the gap.
  task automatic add_gap(ref text_q_t text);
    add_filler(text, $urandom_range(0, 4));
    if ($urandom_range(0, 3) == 0) begin
      text.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      add_filler(text, $urandom_range(0, 2));
    end
  endtask

  // Drop the final character now and then, so near misses get through too.
  function automatic string maybe_cut(input string w, input int pct);
    if ($urandom_range(0, 99) < pct) begin
      return w.substr(0, w.len() - 2);
    end
    return w;
  endfunction

  task automatic build_request(output text_q_t text);
    string heads [4] = '{"union", "drop", "update", "insert"};
    string tails [4] = '{"select", "table", "set", "values"};
    string exact [5] = '{"--", ";", "/*", "*/", "="};
    int h;
    int t;
    text = {};
    if ($urandom_range(0, 1)) add_filler(text, $urandom_range(1, 4));
    case ($urandom_range(0, 9))
      0, 1: begin
        h = $urandom_range(0, 3);
        t = ($urandom_range(0, 3) != 0) ? h : $urandom_range(0, 3);
        add_word(text, heads[h]);
        if (h == 3) begin
          // insert needs whitespace before into; an empty run breaks it
          add_space_run(text, $urandom_range(0, 2));
          add_word(text, maybe_cut("into", 10));
        end
        add_gap(text);
        add_word(text, maybe_cut(tails[t], 15));
      end
      2: begin
        add_word(text, "delete");
        add_space_run(text, $urandom_range(0, 3));
        add_word(text, maybe_cut("from", 15));
      end
      3: begin
        if ($urandom_range(0, 3) == 0) begin
          // a split two-byte string must not match
          text.push_back("-");
          add_filler(text, 1);
          text.push_back("-");
        end else begin
          add_word(text, exact[$urandom_range(0, 4)]);
        end
      end
      4, 5: add_word(text, maybe_cut(script_keyword[$urandom_range(0, XSS_WORDS - 1)], 30));
      6: repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      default: add_filler(text, $urandom_range(1, 8));
    endcase
    if ($urandom_range(0, 1)) add_filler(text, $urandom_range(1, 3));
  endtask

  // Counts near the threshold matter most; the extremes come up too.
  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return rate_limit;
      2: return rate_limit + 16'd1;
      3: return rate_limit - 16'd1;
      4: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // --- tests ---------------------------------------------------------------

  // One-byte requests at reset threshold: rate compare at and above the
  // limit, a NUL byte, a last byte that is itself a signature, SQL over rate.
  task automatic test_single_byte_requests();
    text_q_t text;
    send_string("a", 16'd51);
    send_string("a", 16'd50);
    text = {8'h00};
    send_request(text, 16'hFFFF);
    send_string(";", 16'd0);
    send_string("=", 16'hFFFF);
    text = {8'hFF};
    send_request(text, 16'd0);
  endtask

  // Case folding and its limits, SQL over script priority, and matcher state
  // clearing at the end of a request.
  task automatic test_folding_edges();
    text_q_t text;
    send_string("<IMG", 16'd0);
    // 0xC7 is 'G' with the top bit set: must not fold
    text = {"<", "i", "m", 8'hC7};
    send_request(text, 16'd0);
    send_string("<img;", 16'd0);
    // a dash at the end of one request and the start of the next is no "--"
    send_string("x-", 16'd0);
    send_string("-", 16'd0);
  endtask

  // Threshold extremes, wide write data, readback and a write past the map.
  task automatic test_rate_threshold();
    wait_for_verdicts();
    check_threshold_readback();
    apb_write(RATE_THRESHOLD_ADDR, 32'd0);
    send_string("a", 16'd0);
    send_string("b", 16'd1);
    wait_for_verdicts();
    apb_write(RATE_THRESHOLD_ADDR, 32'h0000_FFFF);
    send_string("c", 16'hFFFF);
    wait_for_verdicts();
    // upper data bits are not part of the register
    apb_write(RATE_THRESHOLD_ADDR, 32'hFFFF_00C8);
    check_threshold_readback();
    apb_write(UNMAPPED_ADDR, 32'h0000_0007);
    check_threshold_readback();
    send_string("d", 16'd200);
    send_string("e", 16'd201);
    wait_for_verdicts();
  endtask

  // Hold the sink off for a long stretch while requests keep coming, so a
  // verdict waits in the output stage and the next last byte stalls the input.
  task automatic test_output_backpressure();
    bit saved_gaps;
    saved_gaps = src_gaps_on;
    src_gaps_on = 1'b0;
    sink_hold_cycles = LONG_HOLD;
    send_string("union all select", 16'd0);
    send_string("onerror=x", 16'd0);
    send_string("q1", 16'd300);
    send_string("abc", 16'd5);
    send_string("drop\ttable", 16'd0);
    src_gaps_on = saved_gaps;
    wait_for_verdicts();
  endtask

  // Random requests over several threshold settings; each setting is written
  // with the block idle.
  task automatic test_random_requests();
    logic [15:0] limits [4];
    text_q_t text;
    int phase_bytes;
    int phase_verdicts;
    limits = '{16'($urandom_range(1, 65534)), 16'd0, 16'hFFFF, RATE_THRESHOLD_RESET};
    foreach (limits[p]) begin
      wait_for_verdicts();
      apb_write(RATE_THRESHOLD_ADDR, {16'($urandom_range(0, 65535)), limits[p]});
      phase_bytes = 0;
      phase_verdicts = 0;
      while (phase_bytes < RANDOM_PHASE_BYTES || phase_verdicts < RANDOM_PHASE_MIN_VERDICTS) begin
        // now and then run a stretch of back-to-back bytes
        if ($urandom_range(0, 6) == 0) src_gaps_on = !src_gaps_on;
        build_request(text);
        send_request(text, pick_count());
        phase_bytes += text.size();
        phase_verdicts++;
      end
    end
    src_gaps_on = 1'b1;
  endtask

  // --- verdict side --------------------------------------------------------

  // Drive ready: random stalls, short mostly, plus the long hold on request.
  initial begin : verdict_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) sink_gaps_on = !sink_gaps_on;
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every verdict transaction with the oldest prediction.
  always @(posedge clk) begin : check_verdicts
    logic [1:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with no request pending", out_ch.verdict));
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.verdict !== want) begin
          report_mismatch($sformatf("verdict %0d, want %0d", out_ch.verdict, want));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.request_count = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rate_limit = RATE_THRESHOLD_RESET;
    clear_scan_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_single_byte_requests();
    test_folding_edges();
    test_rate_threshold();
    test_output_backpressure();
    test_random_requests();

    wait_for_verdicts();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
